>>> rtl/bioprf_pkg.sv
// ----------------------------------------------------------------------------
// bioprf_pkg: shared types and codes
// Transaction payloads, function codes, response codes and the register
// file entry layout of the bus I/O page register file.
// ----------------------------------------------------------------------------
package bioprf_pkg;

    localparam int ADDR_W = 23;
    localparam int DATA_W = 16;
    localparam int HANDLE_W = 8;
    localparam int LIMIT_W = 24;
    localparam int CFG_DATA_W = 24;

    // Function codes
    localparam logic [2:0] FUNC_READ_WORD  = 3'd0;
    localparam logic [2:0] FUNC_WRITE_WORD = 3'd1;
    localparam logic [2:0] FUNC_WRITE_BYTE = 3'd2;
    localparam logic [2:0] FUNC_LOAD_PAGE  = 3'd3;
    localparam logic [2:0] FUNC_LOAD_REG   = 3'd4;

    // Response status
    localparam logic [1:0] STATUS_NONE = 2'd0;
    localparam logic [1:0] STATUS_MEM  = 2'd1;
    localparam logic [1:0] STATUS_REG  = 2'd2;

    // Backing memory operation
    localparam logic [1:0] MEM_OP_NONE       = 2'd0;
    localparam logic [1:0] MEM_OP_READ_WORD  = 2'd1;
    localparam logic [1:0] MEM_OP_WRITE_WORD = 2'd2;
    localparam logic [1:0] MEM_OP_WRITE_BYTE = 2'd3;

    // Configuration register indexes
    localparam logic CFG_WINDOW_START = 1'b0;
    localparam logic CFG_WINDOW_LIMIT = 1'b1;

    localparam logic [DATA_W-1:0] LOW_LANE  = 16'h00ff;
    localparam logic [DATA_W-1:0] HIGH_LANE = 16'hff00;

    typedef struct packed {
        logic [2:0]          func;
        logic [ADDR_W-1:0]   addr;
        logic [DATA_W-1:0]   data;
        logic [HANDLE_W-1:0] handle;
        logic [DATA_W-1:0]   writable_mask;
        logic [1:0]          event_enables;
    } req_t;

    typedef struct packed {
        logic [1:0]          status;
        logic [1:0]          mem_op;
        logic [ADDR_W-1:0]   mem_addr;
        logic [DATA_W-1:0]   mem_wdata;
        logic [DATA_W-1:0]   reg_value;
        logic                event_raise;
        logic [1:0]          event_cycle;
        logic [HANDLE_W-1:0] reg_handle;
    } rsp_t;

    typedef struct packed {
        logic [DATA_W-1:0] value;
        logic [DATA_W-1:0] mask;
        logic [1:0]        events;
    } rf_entry_t;

    typedef struct packed {
        logic rd;
        logic wr;
    } mem_cmd_t;

endpackage

>>> rtl/bioprf_idx.sv
// ----------------------------------------------------------------------------
// bioprf_idx: page index unit
// Reduces a bus word address modulo the page table depth. A power-of-two
// depth is a plain bit slice; any other depth takes one restoring
// compare-and-subtract step per cycle.
// ----------------------------------------------------------------------------
module bioprf_idx #(
    parameter int PAGE_WORDS = 4096
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [bioprf_pkg::ADDR_W-2:0] word_addr,
    output logic [$clog2(PAGE_WORDS)-1:0] idx,
    output logic                          done
);

    localparam int XW = bioprf_pkg::ADDR_W - 1;
    localparam int PW = $clog2(PAGE_WORDS);
    localparam bit POW2 = (PAGE_WORDS & (PAGE_WORDS - 1)) == 0;
    localparam int STEPS = POW2 ? 1 : (XW + 1 - PW);
    localparam int SW = $clog2(STEPS + 1);
    localparam int DW = XW + 2;

    logic [XW-1:0] rem_reg;
    logic [XW-1:0] rem_next;
    logic [SW-1:0] step_reg;
    logic          busy_reg;
    logic [DW-1:0] sub;
    logic          fits;

    assign sub = DW'(PAGE_WORDS) << step_reg;
    assign fits = {2'b00, rem_reg} >= sub;
    assign rem_next = fits ? (rem_reg - sub[XW-1:0]) : rem_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            step_reg <= '0;
        end
        else if (start)
        begin
            busy_reg <= !POW2;
            step_reg <= SW'(STEPS - 1);
        end
        else if (busy_reg)
        begin
            if (step_reg == '0)
            begin
                busy_reg <= 1'b0;
            end
            step_reg <= step_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= word_addr;
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_next;
        end
    end

    assign idx = rem_reg[PW-1:0];
    assign done = !busy_reg;

endmodule

>>> rtl/bioprf_page.sv
// ----------------------------------------------------------------------------
// bioprf_page: page table memory
// One handle per bus word in a synchronous RAM with registered read data.
// After reset a sweep writes zero to every entry before ready rises.
// ----------------------------------------------------------------------------
module bioprf_page #(
    parameter int PAGE_WORDS = 4096
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  bioprf_pkg::mem_cmd_t                cmd,
    input  logic [$clog2(PAGE_WORDS)-1:0]       addr,
    input  logic [bioprf_pkg::HANDLE_W-1:0]     wdata,
    output logic [bioprf_pkg::HANDLE_W-1:0]     rdata,
    output logic                                ready
);

    localparam int PW = $clog2(PAGE_WORDS);

    logic [bioprf_pkg::HANDLE_W-1:0] pt_mem [PAGE_WORDS];
    logic [bioprf_pkg::HANDLE_W-1:0] rdata_reg;
    logic [PW-1:0]                   clr_idx_reg;
    logic                            clr_busy_reg;
    logic                            wr_en;
    logic [PW-1:0]                   wr_addr;
    logic [bioprf_pkg::HANDLE_W-1:0] wr_data;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_idx_reg <= '0;
            clr_busy_reg <= 1'b1;
        end
        else if (clr_busy_reg)
        begin
            if (clr_idx_reg == PW'(PAGE_WORDS - 1))
            begin
                clr_busy_reg <= 1'b0;
            end
            clr_idx_reg <= clr_idx_reg + 1'b1;
        end
    end

    // the sweep owns the write port until it finishes
    assign wr_en = clr_busy_reg || cmd.wr;
    assign wr_addr = clr_busy_reg ? clr_idx_reg : addr;
    assign wr_data = clr_busy_reg ? '0 : wdata;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            pt_mem[wr_addr] <= wr_data;
        end
        if (cmd.rd)
        begin
            rdata_reg <= pt_mem[addr];
        end
    end

    assign rdata = rdata_reg;
    assign ready = !clr_busy_reg;

endmodule

>>> rtl/bioprf_regs.sv
// ----------------------------------------------------------------------------
// bioprf_regs: device register file
// Value, writable mask and event enables per handle in one synchronous RAM.
// Per-entry valid flags make an entry never written since reset read as zero.
// ----------------------------------------------------------------------------
module bioprf_regs #(
    parameter int REG_COUNT = 256
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  bioprf_pkg::mem_cmd_t           cmd,
    input  logic [$clog2(REG_COUNT)-1:0]   addr,
    input  bioprf_pkg::rf_entry_t          wdata,
    output bioprf_pkg::rf_entry_t          rdata
);

    bioprf_pkg::rf_entry_t rf_mem [REG_COUNT];
    bioprf_pkg::rf_entry_t rdata_reg;
    logic [REG_COUNT-1:0]  vld_reg;
    logic                  rd_vld_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
            rd_vld_reg <= 1'b0;
        end
        else
        begin
            if (cmd.wr)
            begin
                vld_reg[addr] <= 1'b1;
            end
            if (cmd.rd)
            begin
                rd_vld_reg <= vld_reg[addr];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.wr)
        begin
            rf_mem[addr] <= wdata;
        end
        if (cmd.rd)
        begin
            rdata_reg <= rf_mem[addr];
        end
    end

    assign rdata = rd_vld_reg ? rdata_reg : '0;

endmodule

>>> rtl/bus_io_page_register_file_top.sv
// Loads and unused codes post their result from the index state; memory window, ROM
// and unanswered accesses post after the page table read, device registers after the
// register file read as well; a PAGE_WORDS that is not a power of two adds the restoring index steps.
// One transaction at a time: the next is accepted only after the result posts.
// Reset: window registers clear, register file reads zero at once, and the page
// table is swept with req_stall high.
// ----------------------------------------------------------------------------
// bus_io_page_register_file_top: bus I/O page register file
// Decodes bus accesses into memory window requests, ROM reads or device
// register accesses through a page table, and takes host load operations.
// ----------------------------------------------------------------------------
module bus_io_page_register_file_top #(
    parameter int PAGE_WORDS = 4096,
    parameter int REG_COUNT = 256,
    parameter int IOPAGE_BIT = 22,
    parameter int ROM_HANDLE = 255
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_write,
    input  logic                                 cfg_index,
    input  logic [bioprf_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  logic                                 req_valid,
    output logic                                 req_stall,
    input  bioprf_pkg::req_t                     req,
    output logic                                 rsp_valid,
    input  logic                                 rsp_stall,
    output bioprf_pkg::rsp_t                     rsp
);

    localparam int PW = $clog2(PAGE_WORDS);
    localparam int RW = $clog2(REG_COUNT);
    localparam logic [bioprf_pkg::HANDLE_W-1:0] ROM_H = bioprf_pkg::HANDLE_W'(ROM_HANDLE);
    localparam logic [bioprf_pkg::HANDLE_W:0] REG_LIMIT = (bioprf_pkg::HANDLE_W + 1)'(REG_COUNT);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_INDEX = 2'd1;
    localparam logic [1:0] ST_PAGE  = 2'd2;
    localparam logic [1:0] ST_REG   = 2'd3;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    logic [bioprf_pkg::ADDR_W-1:0]  win_start_reg;
    logic [bioprf_pkg::LIMIT_W-1:0] win_limit_reg;

    bioprf_pkg::req_t item_reg;
    bioprf_pkg::rsp_t rsp_reg;
    bioprf_pkg::rsp_t res;
    logic             rsp_valid_reg;

    logic req_accept;
    logic out_free;
    logic emit;
    logic idx_start;
    logic idx_done;
    logic [PW-1:0] page_idx;
    logic pt_ready;

    bioprf_pkg::mem_cmd_t            pt_cmd;
    logic [bioprf_pkg::HANDLE_W-1:0] pt_rdata;
    bioprf_pkg::mem_cmd_t            rf_cmd;
    logic [RW-1:0]                   rf_addr;
    bioprf_pkg::rf_entry_t           rf_wdata;
    bioprf_pkg::rf_entry_t           rf_rdata;

    logic                            is_bus;
    logic                            is_read;
    logic                            in_window;
    logic                            in_iopage;
    logic                            load_ok;
    logic                            reg_hit;
    logic [bioprf_pkg::HANDLE_W-1:0] h;
    logic [bioprf_pkg::DATA_W-1:0]   lane_byte;
    logic [bioprf_pkg::DATA_W-1:0]   new_value;
    bioprf_pkg::rsp_t                page_res;
    bioprf_pkg::rsp_t                reg_res;

    bioprf_idx #(
        .PAGE_WORDS(PAGE_WORDS)
    ) u_idx (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (idx_start),
        .word_addr(req.addr[bioprf_pkg::ADDR_W-1:1]),
        .idx      (page_idx),
        .done     (idx_done)
    );

    bioprf_page #(
        .PAGE_WORDS(PAGE_WORDS)
    ) u_page (
        .clk  (clk),
        .rst_n(rst_n),
        .cmd  (pt_cmd),
        .addr (page_idx),
        .wdata(item_reg.handle),
        .rdata(pt_rdata),
        .ready(pt_ready)
    );

    bioprf_regs #(
        .REG_COUNT(REG_COUNT)
    ) u_regs (
        .clk  (clk),
        .rst_n(rst_n),
        .cmd  (rf_cmd),
        .addr (rf_addr),
        .wdata(rf_wdata),
        .rdata(rf_rdata)
    );

    // configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win_start_reg <= '0;
            win_limit_reg <= '0;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                bioprf_pkg::CFG_WINDOW_START:
                    win_start_reg <= cfg_data[bioprf_pkg::ADDR_W-1:0];
                bioprf_pkg::CFG_WINDOW_LIMIT:
                    win_limit_reg <= cfg_data[bioprf_pkg::LIMIT_W-1:0];
            endcase
        end
    end

    assign req_stall = !(state_reg == ST_IDLE && pt_ready);
    assign req_accept = req_valid && !req_stall;
    assign out_free = !rsp_valid_reg || !rsp_stall;

    // decode of the held transaction
    assign h = pt_rdata;
    assign is_bus = item_reg.func <= bioprf_pkg::FUNC_WRITE_BYTE;
    assign is_read = item_reg.func == bioprf_pkg::FUNC_READ_WORD;
    assign in_window = ({1'b0, item_reg.addr} < win_limit_reg)
                    && (item_reg.addr >= win_start_reg);
    assign in_iopage = item_reg.addr[IOPAGE_BIT];
    assign load_ok = {1'b0, item_reg.handle} < REG_LIMIT;
    assign reg_hit = is_bus && !in_window && in_iopage && (h != '0) && (h != ROM_H)
                  && ({1'b0, h} < REG_LIMIT);

    always_comb
    begin
        page_res = '0;
        if (in_window)
        begin
            page_res.status = bioprf_pkg::STATUS_MEM;
            page_res.mem_addr = item_reg.addr;
            unique case (item_reg.func[1:0])
                bioprf_pkg::FUNC_READ_WORD[1:0]:
                    page_res.mem_op = bioprf_pkg::MEM_OP_READ_WORD;
                bioprf_pkg::FUNC_WRITE_WORD[1:0]:
                begin
                    page_res.mem_op = bioprf_pkg::MEM_OP_WRITE_WORD;
                    page_res.mem_wdata = item_reg.data;
                end
                default:
                begin
                    page_res.mem_op = bioprf_pkg::MEM_OP_WRITE_BYTE;
                    page_res.mem_wdata = item_reg.data & bioprf_pkg::LOW_LANE;
                end
            endcase
        end
        else if (in_iopage && h == ROM_H && is_read)
        begin
            page_res.status = bioprf_pkg::STATUS_MEM;
            page_res.mem_op = bioprf_pkg::MEM_OP_READ_WORD;
            page_res.mem_addr = item_reg.addr;
        end
    end

    // merge the write under the writable mask
    always_comb
    begin
        lane_byte = '0;
        new_value = rf_rdata.value;
        if (item_reg.func == bioprf_pkg::FUNC_WRITE_WORD)
        begin
            new_value = (rf_rdata.value & ~rf_rdata.mask) | (item_reg.data & rf_rdata.mask);
        end
        else if (item_reg.func == bioprf_pkg::FUNC_WRITE_BYTE)
        begin
            if (item_reg.addr[0])
            begin
                lane_byte = {item_reg.data[7:0], 8'h00};
                new_value = (rf_rdata.value & bioprf_pkg::LOW_LANE)
                          | (rf_rdata.value & ~rf_rdata.mask & bioprf_pkg::HIGH_LANE)
                          | (lane_byte & rf_rdata.mask);
            end
            else
            begin
                lane_byte = {8'h00, item_reg.data[7:0]};
                new_value = (rf_rdata.value & bioprf_pkg::HIGH_LANE)
                          | (rf_rdata.value & ~rf_rdata.mask & bioprf_pkg::LOW_LANE)
                          | (lane_byte & rf_rdata.mask);
            end
        end
    end

    always_comb
    begin
        reg_res = '0;
        reg_res.status = bioprf_pkg::STATUS_REG;
        reg_res.reg_value = new_value;
        reg_res.event_raise = is_read ? rf_rdata.events[0] : rf_rdata.events[1];
        reg_res.event_cycle = item_reg.func[1:0];
        reg_res.reg_handle = h;
    end

    always_comb
    begin
        state_next = state_reg;
        idx_start = 1'b0;
        pt_cmd = '0;
        rf_cmd = '0;
        rf_addr = (state_reg == ST_INDEX) ? item_reg.handle[RW-1:0] : h[RW-1:0];
        rf_wdata = '{value: item_reg.data, mask: item_reg.writable_mask,
                     events: item_reg.event_enables};
        emit = 1'b0;
        res = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (req_accept)
                begin
                    idx_start = 1'b1;
                    state_next = ST_INDEX;
                end
            end
            ST_INDEX:
            begin
                if (idx_done)
                begin
                    if (is_bus)
                    begin
                        pt_cmd.rd = 1'b1;
                        state_next = ST_PAGE;
                    end
                    else
                    begin
                        // loads are idempotent, so repeat them while the result waits
                        pt_cmd.wr = item_reg.func == bioprf_pkg::FUNC_LOAD_PAGE;
                        rf_cmd.wr = (item_reg.func == bioprf_pkg::FUNC_LOAD_REG) && load_ok;
                        if (out_free)
                        begin
                            emit = 1'b1;
                            state_next = ST_IDLE;
                        end
                    end
                end
            end
            ST_PAGE:
            begin
                if (reg_hit)
                begin
                    rf_cmd.rd = 1'b1;
                    state_next = ST_REG;
                end
                else if (out_free)
                begin
                    emit = 1'b1;
                    res = page_res;
                    state_next = ST_IDLE;
                end
            end
            ST_REG:
            begin
                rf_wdata = '{value: new_value, mask: rf_rdata.mask, events: rf_rdata.events};
                if (out_free)
                begin
                    emit = 1'b1;
                    res = reg_res;
                    rf_cmd.wr = !is_read;
                    state_next = ST_IDLE;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (emit)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (!rsp_stall)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_accept)
        begin
            item_reg <= req;
        end
        if (emit)
        begin
            rsp_reg <= res;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp = rsp_reg;

endmodule

>>> rtl/bioprf_checker.sv
// ----------------------------------------------------------------------------
// bioprf_checker: port-level checks
// Watches the transaction channels of the top level and flags responses
// whose fields contradict each other or a broken one-at-a-time flow.
// ----------------------------------------------------------------------------
module bioprf_checker (
    input logic             clk,
    input logic             rst_n,
    input logic             req_valid,
    input logic             req_stall,
    input logic             rsp_valid,
    input logic             rsp_stall,
    input bioprf_pkg::rsp_t rsp
);

    // hold a stalled response
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
    else $error("stalled response changed");

    // one transaction in flight: stall right after an accept
    assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && !req_stall |=> req_stall)
    else $error("request accepted back to back");

    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.status != bioprf_pkg::STATUS_REG |->
            rsp.reg_value == '0 && rsp.reg_handle == '0
            && !rsp.event_raise && rsp.event_cycle == '0)
    else $error("register fields set without register access");

    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (rsp.status == bioprf_pkg::STATUS_MEM) |->
            rsp.mem_op != bioprf_pkg::MEM_OP_NONE)
    else $error("memory status without memory operation");

    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.mem_op == bioprf_pkg::MEM_OP_NONE |->
            rsp.mem_addr == '0 && rsp.mem_wdata == '0
            && rsp.status != bioprf_pkg::STATUS_MEM)
    else $error("memory fields set without memory operation");

endmodule

bind bus_io_page_register_file_top bioprf_checker u_chk (.*);

>>> bench/tb_bus_io_page_register_file_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_bus_io_page_register_file_top: bus I/O page register file testbench
// Sends bus accesses and host load operations over the valid/stall request
// channel. A behavioral copy of the window registers, the page table and the
// register file predicts each response, and responses are checked in order.
// Sender bursts, receiver stall patterns and one long hold-off vary the pacing.
// ----------------------------------------------------------------------------
module tb_bus_io_page_register_file_top;
    import bioprf_pkg::*;

    localparam int PAGE_WORDS = 4096;
    localparam int REG_COUNT = 256;
    localparam int IOPAGE_BIT = 22;
    localparam int ROM_HANDLE = 255;
    localparam int PIDX_W = $clog2(PAGE_WORDS);
    localparam int LIVE_HANDLES = 15;
    localparam int PHASE_ITEMS = 220;
    localparam int RANDOM_PHASES = 6;
    localparam int HOLD_CYCLES = 300;
    localparam int END_WAIT = 16;
    localparam int IDLE_LIMIT = 4 * (PAGE_WORDS + HOLD_CYCLES + 100);
    localparam int MAX_REPORTS = 10;

    localparam logic [2:0] FUNC_UNUSED_FIRST = 3'd5;
    localparam logic [2:0] FUNC_UNUSED_LAST = 3'd7;

    typedef enum {STALL_NONE, STALL_LIGHT, STALL_BEAT, STALL_HEAVY} stall_mode_e;

    logic clk = 1'b0;
    logic rst_n;
    logic cfg_write;
    logic cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic req_valid;
    logic req_stall;
    req_t req;
    logic rsp_valid;
    logic rsp_stall;
    rsp_t rsp;

    // Behavioral state of the block
    logic [HANDLE_W-1:0] page_map [PAGE_WORDS];
    logic [DATA_W-1:0] reg_value_m [REG_COUNT];
    logic [DATA_W-1:0] reg_mask_m [REG_COUNT];
    logic [1:0] reg_events_m [REG_COUNT];
    logic [ADDR_W-1:0] win_start;
    logic [LIMIT_W-1:0] win_limit;

    rsp_t due_responses [$];
    int unsigned mapped_pages [$];
    rsp_t oldest_due;
    string field_errors;

    int unsigned fail_count = 0;
    int unsigned n_items = 0;
    int unsigned n_checked = 0;
    int unsigned n_mem = 0;
    int unsigned n_reg = 0;
    int unsigned n_quiet = 0;
    int unsigned n_events = 0;
    int unsigned n_windows = 0;
    int unsigned burst_left = 0;

    bit hold_req = 1'b0;
    int unsigned hold_left = 0;
    stall_mode_e stall_mode = STALL_NONE;
    int unsigned mode_left = 0;
    int unsigned stall_phase = 0;

    bus_io_page_register_file_top #(
        .PAGE_WORDS(PAGE_WORDS),
        .REG_COUNT(REG_COUNT),
        .IOPAGE_BIT(IOPAGE_BIT),
        .ROM_HANDLE(ROM_HANDLE)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_write(cfg_write),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .req_valid(req_valid),
        .req_stall(req_stall),
        .req(req),
        .rsp_valid(rsp_valid),
        .rsp_stall(rsp_stall),
        .rsp(rsp)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Decode one transaction against the behavioral state and update it
    function automatic rsp_t decode_access(req_t r);
        rsp_t o;
        int unsigned pidx;
        int unsigned h;
        logic [DATA_W-1:0] v;
        logic [DATA_W-1:0] m;
        logic [DATA_W-1:0] b;
        o = '0;
        pidx = (r.addr >> 1) % PAGE_WORDS;
        if (r.func == FUNC_LOAD_PAGE)
        begin
            page_map[pidx] = r.handle;
        end
        else if (r.func == FUNC_LOAD_REG)
        begin
            if (r.handle < REG_COUNT)
            begin
                reg_value_m[r.handle] = r.data;
                reg_mask_m[r.handle] = r.writable_mask;
                reg_events_m[r.handle] = r.event_enables;
            end
        end
        else if (r.func == FUNC_READ_WORD || r.func == FUNC_WRITE_WORD ||
                 r.func == FUNC_WRITE_BYTE)
        begin
            if (r.addr < win_limit && r.addr >= win_start)
            begin
                o.status = STATUS_MEM;
                o.mem_addr = r.addr;
                if (r.func == FUNC_READ_WORD)
                begin
                    o.mem_op = MEM_OP_READ_WORD;
                end
                else if (r.func == FUNC_WRITE_WORD)
                begin
                    o.mem_op = MEM_OP_WRITE_WORD;
                    o.mem_wdata = r.data;
                end
                else
                begin
                    o.mem_op = MEM_OP_WRITE_BYTE;
                    o.mem_wdata = r.data & LOW_LANE;
                end
            end
            else if (r.addr[IOPAGE_BIT])
            begin
                h = page_map[pidx];
                if (h == ROM_HANDLE)
                begin
                    // ROM answers reads only
                    if (r.func == FUNC_READ_WORD)
                    begin
                        o.status = STATUS_MEM;
                        o.mem_op = MEM_OP_READ_WORD;
                        o.mem_addr = r.addr;
                    end
                end
                else if (h != 0 && h < REG_COUNT)
                begin
                    v = reg_value_m[h];
                    m = reg_mask_m[h];
                    if (r.func == FUNC_READ_WORD)
                    begin
                        o.event_raise = reg_events_m[h][0];
                    end
                    else
                    begin
                        if (r.func == FUNC_WRITE_WORD)
                        begin
                            v = (v & ~m) | (r.data & m);
                        end
                        else if (r.addr[0])
                        begin
                            b = (r.data & LOW_LANE) << 8;
                            v = (v & LOW_LANE) | (v & ~m & HIGH_LANE) | (b & m);
                        end
                        else
                        begin
                            b = r.data & LOW_LANE;
                            v = (v & HIGH_LANE) | (v & ~m & LOW_LANE) | (b & m);
                        end
                        reg_value_m[h] = v;
                        o.event_raise = reg_events_m[h][1];
                    end
                    o.status = STATUS_REG;
                    o.reg_value = v;
                    o.event_cycle = r.func[1:0];
                    o.reg_handle = h[HANDLE_W-1:0];
                end
            end
        end
        return o;
    endfunction

    function automatic string field_diff(rsp_t got, rsp_t want);
        string s;
        s = "";
        if (got.status !== want.status)
            s = {s, $sformatf(" status %0d/%0d", want.status, got.status)};
        if (got.mem_op !== want.mem_op)
            s = {s, $sformatf(" mem_op %0d/%0d", want.mem_op, got.mem_op)};
        if (got.mem_addr !== want.mem_addr)
            s = {s, $sformatf(" mem_addr %h/%h", want.mem_addr, got.mem_addr)};
        if (got.mem_wdata !== want.mem_wdata)
            s = {s, $sformatf(" mem_wdata %h/%h", want.mem_wdata, got.mem_wdata)};
        if (got.reg_value !== want.reg_value)
            s = {s, $sformatf(" reg_value %h/%h", want.reg_value, got.reg_value)};
        if (got.event_raise !== want.event_raise)
            s = {s, $sformatf(" event_raise %0d/%0d", want.event_raise, got.event_raise)};
        if (got.event_cycle !== want.event_cycle)
            s = {s, $sformatf(" event_cycle %0d/%0d", want.event_cycle, got.event_cycle)};
        if (got.reg_handle !== want.reg_handle)
            s = {s, $sformatf(" reg_handle %0d/%0d", want.reg_handle, got.reg_handle)};
        return s;
    endfunction

    function automatic void note_failure(string msg);
        fail_count++;
        if (fail_count <= MAX_REPORTS)
            $display("%t: %s", $time, msg);
    endfunction

    function automatic void remember_page(int unsigned idx);
        if (mapped_pages.size() < 32)
            mapped_pages.push_back(idx);
        else
            mapped_pages[$urandom_range(0, 31)] = idx;
    endfunction

    function automatic logic [ADDR_W-1:0] io_addr(int unsigned idx);
        logic [ADDR_W-1:0] a;
        a = ADDR_W'($urandom);
        a[IOPAGE_BIT] = 1'b1;
        a[PIDX_W:1] = idx[PIDX_W-1:0];
        return a;
    endfunction

    function automatic logic [ADDR_W-1:0] pick_bus_addr();
        logic [ADDR_W-1:0] a;
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4, 5:
                a = io_addr(mapped_pages[$urandom_range(0, mapped_pages.size() - 1)]);
            6: a = ADDR_W'(win_start + $urandom_range(0, 3) - 2);
            7: a = ADDR_W'(win_limit + $urandom_range(0, 3) - 2);
            8: a = io_addr($urandom);
            default: a = ADDR_W'($urandom);
        endcase
        return a;
    endfunction

    function automatic logic [HANDLE_W-1:0] pick_handle();
        int unsigned pick;
        pick = $urandom_range(0, 9);
        if (pick < 6)
            return HANDLE_W'($urandom_range(1, LIVE_HANDLES));
        if (pick == 6)
            return HANDLE_W'(ROM_HANDLE);
        if (pick == 7)
            return '0;
        return HANDLE_W'($urandom);
    endfunction

    function automatic req_t random_req();
        req_t r;
        r.func = 3'($urandom_range(0, 7));
        r.addr = ADDR_W'($urandom);
        r.data = DATA_W'($urandom);
        r.handle = HANDLE_W'($urandom);
        r.writable_mask = DATA_W'($urandom);
        r.event_enables = 2'($urandom);
        return r;
    endfunction

    // Present one transaction, hold it until accepted, then predict its response
    task automatic send_item(req_t item);
        int unsigned gap;
        rsp_t expected;
        if (burst_left == 0)
        begin
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 60) :
                                                       $urandom_range(1, 20);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap != 0)
            begin
                @(negedge clk);
                req_valid <= 1'b0;
                repeat (gap - 1) @(negedge clk);
            end
        end
        burst_left--;
        @(negedge clk);
        req_valid <= 1'b1;
        req <= item;
        @(posedge clk);
        while (req_stall !== 1'b0)
            @(posedge clk);
        expected = decode_access(item);
        due_responses.push_back(expected);
        n_items++;
        case (expected.status)
            STATUS_MEM: n_mem++;
            STATUS_REG: n_reg++;
            default: n_quiet++;
        endcase
        if (expected.event_raise)
            n_events++;
    endtask

    task automatic bus_idle();
        @(negedge clk);
        req_valid <= 1'b0;
        burst_left = 0;
    endtask

    task automatic wait_all_responses();
        bus_idle();
        while (due_responses.size() != 0)
            @(posedge clk);
    endtask

    task automatic set_window(logic [ADDR_W-1:0] start_addr, logic [LIMIT_W-1:0] limit_addr);
        wait_all_responses();
        @(negedge clk);
        cfg_write <= 1'b1;
        cfg_index <= CFG_WINDOW_START;
        cfg_data <= CFG_DATA_W'(start_addr);
        @(negedge clk);
        cfg_index <= CFG_WINDOW_LIMIT;
        cfg_data <= CFG_DATA_W'(limit_addr);
        @(negedge clk);
        cfg_write <= 1'b0;
        win_start = start_addr;
        win_limit = limit_addr;
        n_windows++;
    endtask

    task automatic random_window();
        logic [ADDR_W-1:0] s;
        logic [LIMIT_W-1:0] l;
        case ($urandom_range(0, 3))
            0:
            begin
                s = '0;
                l = LIMIT_W'($urandom_range(0, 24'h400000));
            end
            1:
            begin
                s = ADDR_W'($urandom);
                l = LIMIT_W'($urandom_range(s, 24'h800000));
            end
            2:
            begin
                s = ADDR_W'($urandom);
                l = LIMIT_W'($urandom_range(0, 24'h800000));
            end
            default:
            begin
                s = ADDR_W'($urandom_range(24'h400000, 24'h7fffff));
                l = LIMIT_W'(s + $urandom_range(0, 4096));
                if (l > 24'h800000)
                    l = 24'h800000;
            end
        endcase
        set_window(s, l);
    endtask

    task automatic bus_access(logic [2:0] func, logic [ADDR_W-1:0] addr, logic [DATA_W-1:0] data);
        req_t r;
        r = random_req();
        r.func = func;
        r.addr = addr;
        r.data = data;
        send_item(r);
    endtask

    task automatic load_page(logic [ADDR_W-1:0] addr, logic [HANDLE_W-1:0] handle);
        req_t r;
        r = random_req();
        r.func = FUNC_LOAD_PAGE;
        r.addr = addr;
        r.handle = handle;
        remember_page((addr >> 1) % PAGE_WORDS);
        send_item(r);
    endtask

    task automatic load_reg(logic [HANDLE_W-1:0] handle, logic [DATA_W-1:0] value,
                            logic [DATA_W-1:0] mask, logic [1:0] enables);
        req_t r;
        r = random_req();
        r.func = FUNC_LOAD_REG;
        r.handle = handle;
        r.data = value;
        r.writable_mask = mask;
        r.event_enables = enables;
        send_item(r);
    endtask

    task automatic send_random_item(output bit counted);
        req_t r;
        int unsigned pick;
        r = random_req();
        pick = $urandom_range(0, 99);
        if (pick < 30)
            r.func = FUNC_READ_WORD;
        else if (pick < 52)
            r.func = FUNC_WRITE_WORD;
        else if (pick < 72)
            r.func = FUNC_WRITE_BYTE;
        else if (pick < 82)
            r.func = FUNC_LOAD_PAGE;
        else if (pick < 94)
            r.func = FUNC_LOAD_REG;
        else
            r.func = 3'($urandom_range(FUNC_UNUSED_FIRST, FUNC_UNUSED_LAST));

        if (r.func <= FUNC_WRITE_BYTE)
        begin
            r.addr = pick_bus_addr();
        end
        else if (r.func == FUNC_LOAD_PAGE)
        begin
            if ($urandom_range(0, 4) == 0)
                r.addr = ADDR_W'($urandom);
            else if ($urandom_range(0, 1) == 0)
                r.addr = io_addr(mapped_pages[$urandom_range(0, mapped_pages.size() - 1)]);
            else
                r.addr = io_addr($urandom_range(0, PAGE_WORDS - 1));
            r.handle = pick_handle();
            remember_page((r.addr >> 1) % PAGE_WORDS);
        end
        else if (r.func == FUNC_LOAD_REG)
        begin
            r.handle = ($urandom_range(0, 3) == 0) ? HANDLE_W'($urandom) :
                                                     HANDLE_W'($urandom_range(0, LIVE_HANDLES));
            case ($urandom_range(0, 5))
                0: r.writable_mask = '0;
                1: r.writable_mask = '1;
                default: r.writable_mask = DATA_W'($urandom);
            endcase
        end
        counted = (r.func <= FUNC_LOAD_REG);
        send_item(r);
    endtask

    // Window edges, register merges on both byte lanes, ROM, aliasing, unused codes
    task automatic test_directed();
        req_t r;
        set_window(23'h001000, 24'h002000);
        bus_access(FUNC_READ_WORD, 23'h001000, 16'h0000);
        bus_access(FUNC_WRITE_WORD, 23'h001fff, 16'hbeef);
        bus_access(FUNC_WRITE_BYTE, 23'h001ffe, 16'habcd);
        bus_access(FUNC_READ_WORD, 23'h002000, 16'h0000);
        bus_access(FUNC_WRITE_WORD, 23'h000fff, 16'h1111);
        bus_access(FUNC_READ_WORD, 23'h400010, 16'h0000);
        load_page(23'h400010, 8'd5);
        load_reg(8'd5, 16'h1234, 16'hff0f, 2'b11);
        bus_access(FUNC_READ_WORD, 23'h400010, 16'h0000);
        bus_access(FUNC_WRITE_WORD, 23'h400011, 16'hffff);
        bus_access(FUNC_WRITE_BYTE, 23'h400010, 16'hff00);
        bus_access(FUNC_WRITE_BYTE, 23'h400011, 16'h0055);
        // same entry modulo the page size
        bus_access(FUNC_READ_WORD, 23'h402010, 16'h0000);
        load_page(23'h7fffff, HANDLE_W'(ROM_HANDLE));
        load_reg(HANDLE_W'(ROM_HANDLE), 16'hffff, 16'hffff, 2'b11);
        bus_access(FUNC_READ_WORD, 23'h7ffffe, 16'hffff);
        bus_access(FUNC_WRITE_WORD, 23'h7ffffe, 16'hffff);
        bus_access(FUNC_WRITE_BYTE, 23'h7fffff, 16'hffff);
        load_page(23'h400020, 8'd7);
        load_reg(8'd7, 16'hffff, 16'h0000, 2'b00);
        bus_access(FUNC_WRITE_WORD, 23'h400020, 16'h0000);
        for (int c = FUNC_UNUSED_FIRST; c <= FUNC_UNUSED_LAST; c++)
        begin
            r = '1;
            r.func = 3'(c);
            send_item(r);
        end
    endtask

    task automatic test_window_extremes();
        bit counted;
        for (int s = 0; s < 6; s++)
        begin
            case (s)
                0: set_window(23'h000000, 24'h000000);
                1: set_window(23'h000000, 24'h800000);
                2: set_window(23'h7fffff, 24'h800000);
                3: set_window(23'h400000, 24'h400000);
                4: set_window(23'h600000, 24'h300000);
                default: set_window(23'h3fff00, 24'h400100);
            endcase
            repeat (20)
                send_random_item(counted);
        end
    endtask

    // Hold the response side for a long stretch while requests keep coming
    task automatic test_backpressure();
        bit counted;
        int unsigned n;
        set_window(23'h000000, 24'h100000);
        @(posedge clk);
        hold_req = 1'b1;
        n = 0;
        while (n < 40)
        begin
            send_random_item(counted);
            if (counted)
                n++;
        end
        wait_all_responses();
    endtask

    task automatic test_random_traffic();
        bit counted;
        int unsigned done;
        set_window(23'h000000, 24'h200000);
        // populate registers and page entries so most accesses reach the register file
        for (int h = 1; h <= LIVE_HANDLES; h++)
            load_reg(HANDLE_W'(h), DATA_W'($urandom), DATA_W'($urandom), 2'($urandom));
        for (int k = 0; k < 2 * LIVE_HANDLES; k++)
            load_page(io_addr($urandom_range(0, PAGE_WORDS - 1)),
                      HANDLE_W'($urandom_range(1, LIVE_HANDLES)));
        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            if (p != 0)
                random_window();
            done = 0;
            while (done < PHASE_ITEMS)
            begin
                send_random_item(counted);
                if (counted)
                    done++;
            end
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n === 1'b1 && rsp_valid === 1'b1 && rsp_stall === 1'b0)
        begin
            if (due_responses.size() == 0)
            begin
                note_failure($sformatf("response with nothing outstanding: %p", rsp));
            end
            else
            begin
                oldest_due = due_responses.pop_front();
                field_errors = field_diff(rsp, oldest_due);
                if (field_errors != "")
                    note_failure($sformatf("response %0d mismatch (expected/actual):%s",
                                           n_checked, field_errors));
                n_checked++;
            end
        end
    end

    always @(negedge clk)
    begin
        if (hold_req)
        begin
            hold_left = HOLD_CYCLES;
            hold_req = 1'b0;
        end
        if (mode_left == 0)
        begin
            stall_mode = stall_mode_e'($urandom_range(0, 3));
            mode_left = $urandom_range(16, 160);
        end
        mode_left--;
        stall_phase++;
        if (hold_left != 0)
        begin
            hold_left--;
            rsp_stall <= 1'b1;
        end
        else
        begin
            case (stall_mode)
                STALL_NONE: rsp_stall <= 1'b0;
                STALL_LIGHT: rsp_stall <= ($urandom_range(0, 3) == 0);
                STALL_BEAT: rsp_stall <= (stall_phase % 5 < 2);
                default: rsp_stall <= ($urandom_range(0, 3) != 0);
            endcase
        end
    end

    initial
    begin : watchdog
        int unsigned quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < IDLE_LIMIT)
        begin
            @(posedge clk);
            if ((req_valid === 1'b1 && req_stall === 1'b0) ||
                (rsp_valid === 1'b1 && rsp_stall === 1'b0))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("No transaction for %0d cycles, run stopped", IDLE_LIMIT);
        $display("TB_ERROR");
        $finish;
    end

    initial
    begin
        rst_n = 1'b0;
        cfg_write = 1'b0;
        cfg_index = CFG_WINDOW_START;
        cfg_data = '0;
        req_valid = 1'b0;
        req = '0;
        rsp_stall = 1'b0;
        win_start = '0;
        win_limit = '0;
        foreach (page_map[i])
            page_map[i] = '0;
        foreach (reg_value_m[i])
        begin
            reg_value_m[i] = '0;
            reg_mask_m[i] = '0;
            reg_events_m[i] = '0;
        end
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_directed();
        test_window_extremes();
        test_backpressure();
        test_random_traffic();

        wait_all_responses();
        repeat (END_WAIT) @(posedge clk);
        if (due_responses.size() != 0)
            note_failure($sformatf("%0d responses never arrived", due_responses.size()));

        $display("Sent %0d transactions over %0d window settings: %0d memory/ROM, %0d register,",
                 n_items, n_windows, n_mem, n_reg);
        $display("%0d with no response, %0d host events; %0d responses checked, %0d failures.",
                 n_quiet, n_events, n_checked, fail_count);
        if (fail_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
